### sv/tfo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfo_pkg
// Shared types, widths and arithmetic step functions of the tangent frame
// orthonormalization pipeline.
// ----------------------------------------------------------------------------
package tfo_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int VEC_W         = 16;
    localparam int PROD_W        = 2 * VEC_W;
    localparam int DOT_W         = PROD_W + 2;
    localparam int NORM_W        = 64;
    localparam int MN_W          = 31;
    localparam int SQ_W          = 2 * MN_W;
    localparam int SUM_W         = 64;
    localparam int ROOT_W        = SUM_W / 2;
    localparam int SQ_REM_W      = ROOT_W + 2;
    localparam int SQ_STAGES     = ROOT_W / 2;
    localparam int DREM_W        = ROOT_W + 1;

    typedef struct packed {
        logic signed [VEC_W-1:0] tan_x;
        logic signed [VEC_W-1:0] tan_y;
        logic signed [VEC_W-1:0] tan_z;
        logic signed [VEC_W-1:0] nrm_x;
        logic signed [VEC_W-1:0] nrm_y;
        logic signed [VEC_W-1:0] nrm_z;
        logic signed [VEC_W-1:0] bitan_x;
        logic signed [VEC_W-1:0] bitan_y;
        logic signed [VEC_W-1:0] bitan_z;
        logic                    last_vertex;
    } tfo_in_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] out_x;
        logic signed [VEC_W-1:0] out_y;
        logic signed [VEC_W-1:0] out_z;
        logic                    handed_negative;
        logic                    degenerate;
        logic                    last_out;
    } tfo_out_t;

    // Per-vertex side information carried along the pipeline
    typedef struct packed {
        logic [2:0] neg;
        logic       handed_negative;
        logic       degenerate;
        logic       last;
    } tfo_flags_t;

    typedef struct packed {
        logic [NORM_W-1:0]      mx;
        logic [2:0][NORM_W-1:0] m;
    } tfo_nvec_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
    } tfo_sq_t;

    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic              qbit;
    } tfo_div_t;

    // Width of the signed orthogonalized tangent component
    function automatic int tfo_u_width(int f);
        int a;
        int b;
        a = VEC_W + f;
        b = VEC_W + (DOT_W - f + 1);
        return ((a > b) ? a : b) + 1;
    endfunction

    // Shift all magnitudes left by sh when the top sh bits of the maximum are clear
    function automatic tfo_nvec_t norm_shift(tfo_nvec_t v, int unsigned sh);
        tfo_nvec_t o;
        o = v;
        if ((v.mx >> (NORM_W - sh)) == '0)
        begin
            o.mx = v.mx << sh;
            for (int i = 0; i < 3; i++)
            begin
                o.m[i] = v.m[i] << sh;
            end
        end
        return o;
    endfunction

    // One digit of the integer square root
    function automatic tfo_sq_t sqrt_step(tfo_sq_t s, logic [1:0] pair);
        logic [SQ_REM_W-1:0] r;
        logic [SQ_REM_W-1:0] trial;
        tfo_sq_t             o;
        r     = {s.rem[SQ_REM_W-3:0], pair};
        trial = {s.root, 2'b01};
        if (r >= trial)
        begin
            o.rem  = r - trial;
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = r;
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // One quotient bit of the restoring division
    function automatic tfo_div_t div_step(logic [DREM_W-1:0] rem, logic [ROOT_W-1:0] d,
                                          logic nbit);
        logic [DREM_W-1:0] x;
        tfo_div_t          o;
        x = {rem[ROOT_W-1:0], nbit};
        if (x >= {1'b0, d})
        begin
            o.rem  = x - {1'b0, d};
            o.qbit = 1'b1;
        end
        else
        begin
            o.rem  = x;
            o.qbit = 1'b0;
        end
        return o;
    endfunction

endpackage

### sv/tfo_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfo_front
// Dot product, tangent orthogonalization, handedness determinant and the
// component magnitudes, in five register stages.
// ----------------------------------------------------------------------------
module tfo_front
    import tfo_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int U_W       = tfo_u_width(FRAC_BITS_DEF)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vtx_valid,
    output logic                  vtx_ready,
    input  tfo_in_t               vtx_data,
    output logic                  mag_valid,
    input  logic                  mag_ready,
    output logic [2:0][U_W-1:0]   mag,
    output logic [U_W-1:0]        mag_max,
    output tfo_flags_t            flags
);

    localparam int NS   = 5;
    localparam int D_W  = DOT_W - FRAC_BITS + 1;
    localparam int ND_W = VEC_W + D_W;
    localparam int C_W  = PROD_W + 1;
    localparam int E_W  = C_W + VEC_W;
    localparam int DET_W = E_W + 2;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] adv;
    logic [NS-1:0] v_shift;

    // Pipeline control: a stage advances when empty or when the next one does
    always_comb
    begin
        adv[NS-1] = !v_reg[NS-1] || mag_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign v_shift   = {v_reg[NS-2:0], vtx_valid};
    assign vtx_ready = adv[0];
    assign mag_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_shift[k];
                end
            end
        end
    end

    // Stage 0: products of normal and tangent
    logic signed [VEC_W-1:0]  t_in [3];
    logic signed [VEC_W-1:0]  n_in [3];
    logic signed [VEC_W-1:0]  b_in [3];
    logic signed [PROD_W-1:0] pd0_next [3];
    logic signed [PROD_W-1:0] px0_next [6];
    logic signed [VEC_W-1:0]  t0_reg [3];
    logic signed [VEC_W-1:0]  n0_reg [3];
    logic signed [VEC_W-1:0]  b0_reg [3];
    logic signed [PROD_W-1:0] pd0_reg [3];
    logic signed [PROD_W-1:0] px0_reg [6];
    logic                     last0_reg;

    always_comb
    begin
        t_in[0] = vtx_data.tan_x;
        t_in[1] = vtx_data.tan_y;
        t_in[2] = vtx_data.tan_z;
        n_in[0] = vtx_data.nrm_x;
        n_in[1] = vtx_data.nrm_y;
        n_in[2] = vtx_data.nrm_z;
        b_in[0] = vtx_data.bitan_x;
        b_in[1] = vtx_data.bitan_y;
        b_in[2] = vtx_data.bitan_z;
        for (int i = 0; i < 3; i++)
        begin
            pd0_next[i] = PROD_W'(n_in[i]) * PROD_W'(t_in[i]);
        end
        px0_next[0] = PROD_W'(n_in[1]) * PROD_W'(t_in[2]);
        px0_next[1] = PROD_W'(n_in[2]) * PROD_W'(t_in[1]);
        px0_next[2] = PROD_W'(n_in[2]) * PROD_W'(t_in[0]);
        px0_next[3] = PROD_W'(n_in[0]) * PROD_W'(t_in[2]);
        px0_next[4] = PROD_W'(n_in[0]) * PROD_W'(t_in[1]);
        px0_next[5] = PROD_W'(n_in[1]) * PROD_W'(t_in[0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                t0_reg[i]  <= t_in[i];
                n0_reg[i]  <= n_in[i];
                b0_reg[i]  <= b_in[i];
                pd0_reg[i] <= pd0_next[i];
            end
            for (int i = 0; i < 6; i++)
            begin
                px0_reg[i] <= px0_next[i];
            end
            last0_reg <= vtx_data.last_vertex;
        end
    end

    // Stage 1: round the dot product, form the cross product
    logic signed [DOT_W-1:0] dot_sum;
    logic [DOT_W-1:0]        dot_mag;
    logic [DOT_W-1:0]        dot_rnd;
    logic signed [D_W-1:0]   d1_next;
    logic signed [C_W-1:0]   c1_next [3];
    logic signed [VEC_W-1:0] t1_reg [3];
    logic signed [VEC_W-1:0] n1_reg [3];
    logic signed [VEC_W-1:0] b1_reg [3];
    logic signed [D_W-1:0]   d1_reg;
    logic signed [C_W-1:0]   c1_reg [3];
    logic                    last1_reg;

    always_comb
    begin
        dot_sum = DOT_W'(pd0_reg[0]);
        dot_sum = dot_sum + DOT_W'(pd0_reg[1]) + DOT_W'(pd0_reg[2]);
        dot_mag = dot_sum[DOT_W-1] ? DOT_W'(-dot_sum) : DOT_W'(dot_sum);
        dot_rnd = (dot_mag + (DOT_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        d1_next = dot_sum[DOT_W-1] ? D_W'(-dot_rnd) : D_W'(dot_rnd);
        for (int i = 0; i < 3; i++)
        begin
            c1_next[i] = C_W'(px0_reg[2*i]);
            c1_next[i] = c1_next[i] - C_W'(px0_reg[2*i+1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                t1_reg[i] <= t0_reg[i];
                n1_reg[i] <= n0_reg[i];
                b1_reg[i] <= b0_reg[i];
                c1_reg[i] <= c1_next[i];
            end
            d1_reg    <= d1_next;
            last1_reg <= last0_reg;
        end
    end

    // Stage 2: normal times rounded dot, cross terms times bitangent
    logic signed [ND_W-1:0]  nd2_next [3];
    logic signed [E_W-1:0]   e2_next [3];
    logic signed [VEC_W-1:0] t2_reg [3];
    logic signed [ND_W-1:0]  nd2_reg [3];
    logic signed [E_W-1:0]   e2_reg [3];
    logic                    last2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nd2_next[i] = ND_W'(n1_reg[i]) * ND_W'(d1_reg);
            e2_next[i]  = E_W'(c1_reg[i]) * E_W'(b1_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                t2_reg[i]  <= t1_reg[i];
                nd2_reg[i] <= nd2_next[i];
                e2_reg[i]  <= e2_next[i];
            end
            last2_reg <= last1_reg;
        end
    end

    // Stage 3: orthogonal tangent and sign of the determinant
    logic signed [DET_W-1:0] det_sum;
    logic signed [U_W-1:0]   tw [3];
    logic signed [U_W-1:0]   u3_next [3];
    logic signed [U_W-1:0]   u3_reg [3];
    logic                    hneg3_reg;
    logic                    last3_reg;

    always_comb
    begin
        det_sum = DET_W'(e2_reg[0]);
        det_sum = det_sum + DET_W'(e2_reg[1]) + DET_W'(e2_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            tw[i]      = U_W'(t2_reg[i]);
            u3_next[i] = (tw[i] <<< FRAC_BITS) - U_W'(nd2_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                u3_reg[i] <= u3_next[i];
            end
            hneg3_reg <= det_sum[DET_W-1];
            last3_reg <= last2_reg;
        end
    end

    // Stage 4: magnitudes, signs, maximum and zero test
    logic [2:0][U_W-1:0] m4_next;
    logic [U_W-1:0]      mx4_next;
    tfo_flags_t          fl4_next;
    logic [2:0][U_W-1:0] m4_reg;
    logic [U_W-1:0]      mx4_reg;
    tfo_flags_t          fl4_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m4_next[i]     = u3_reg[i][U_W-1] ? U_W'(-u3_reg[i]) : U_W'(u3_reg[i]);
            fl4_next.neg[i] = u3_reg[i][U_W-1];
        end
        mx4_next = m4_next[0];
        if (m4_next[1] > mx4_next)
        begin
            mx4_next = m4_next[1];
        end
        if (m4_next[2] > mx4_next)
        begin
            mx4_next = m4_next[2];
        end
        fl4_next.handed_negative = hneg3_reg;
        fl4_next.degenerate      = (u3_reg[0] == '0) && (u3_reg[1] == '0) && (u3_reg[2] == '0);
        fl4_next.last            = last3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            m4_reg  <= m4_next;
            mx4_reg <= mx4_next;
            fl4_reg <= fl4_next;
        end
    end

    assign mag     = m4_reg;
    assign mag_max = mx4_reg;
    assign flags   = fl4_reg;

endmodule

### sv/tfo_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfo_norm
// Scales the three magnitudes together so that the largest lies in
// [2^30, 2^31), then forms the sum of their squares. Four register stages.
// ----------------------------------------------------------------------------
module tfo_norm
    import tfo_pkg::*;
#(
    parameter int U_W = tfo_u_width(FRAC_BITS_DEF)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  mag_valid,
    output logic                  mag_ready,
    input  logic [2:0][U_W-1:0]   mag,
    input  logic [U_W-1:0]        mag_max,
    input  tfo_flags_t            flags_in,
    output logic                  sum_valid,
    input  logic                  sum_ready,
    output logic [SUM_W-1:0]      lsum,
    output logic [2:0][MN_W-1:0]  mn,
    output tfo_flags_t            flags_out
);

    localparam int NS = 4;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] adv;
    logic [NS-1:0] v_shift;

    // Pipeline control
    always_comb
    begin
        adv[NS-1] = !v_reg[NS-1] || sum_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign v_shift   = {v_reg[NS-2:0], mag_valid};
    assign mag_ready = adv[0];
    assign sum_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_shift[k];
                end
            end
        end
    end

    // Stage 0: coarse left shifts by 32, 16 and 8
    tfo_nvec_t  vin;
    tfo_nvec_t  v0_next;
    tfo_nvec_t  v0_reg;
    tfo_flags_t fl0_reg;

    always_comb
    begin
        vin.mx = NORM_W'(mag_max);
        for (int i = 0; i < 3; i++)
        begin
            vin.m[i] = NORM_W'(mag[i]);
        end
        v0_next = norm_shift(norm_shift(norm_shift(vin, 32), 16), 8);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            v0_reg  <= v0_next;
            fl0_reg <= flags_in;
        end
    end

    // Stage 1: fine shifts by 4, 2 and 1, keep the top 31 bits
    tfo_nvec_t            v1;
    logic [2:0][MN_W-1:0] mn1_next;
    logic [2:0][MN_W-1:0] mn1_reg;
    tfo_flags_t           fl1_reg;

    always_comb
    begin
        v1 = norm_shift(norm_shift(norm_shift(v0_reg, 4), 2), 1);
        for (int i = 0; i < 3; i++)
        begin
            mn1_next[i] = v1.m[i][NORM_W-1 -: MN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            mn1_reg <= mn1_next;
            fl1_reg <= fl0_reg;
        end
    end

    // Stage 2: squares
    logic [SQ_W-1:0]      sq2_next [3];
    logic [SQ_W-1:0]      sq2_reg [3];
    logic [2:0][MN_W-1:0] mn2_reg;
    tfo_flags_t           fl2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq2_next[i] = SQ_W'(mn1_reg[i]) * SQ_W'(mn1_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq2_reg[i] <= sq2_next[i];
            end
            mn2_reg <= mn1_reg;
            fl2_reg <= fl1_reg;
        end
    end

    // Stage 3: sum of squares
    logic [SUM_W-1:0]     lsum3_next;
    logic [SUM_W-1:0]     lsum3_reg;
    logic [2:0][MN_W-1:0] mn3_reg;
    tfo_flags_t           fl3_reg;

    assign lsum3_next = SUM_W'(sq2_reg[0]) + SUM_W'(sq2_reg[1]) + SUM_W'(sq2_reg[2]);

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            lsum3_reg <= lsum3_next;
            mn3_reg   <= mn2_reg;
            fl3_reg   <= fl2_reg;
        end
    end

    assign lsum      = lsum3_reg;
    assign mn        = mn3_reg;
    assign flags_out = fl3_reg;

endmodule

### sv/tfo_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfo_sqrt
// Pipelined digit-by-digit integer square root of the 64-bit sum of squares,
// two root bits per stage.
// ----------------------------------------------------------------------------
module tfo_sqrt
    import tfo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sum_valid,
    output logic                  sum_ready,
    input  logic [SUM_W-1:0]      lsum,
    input  logic [2:0][MN_W-1:0]  mn_in,
    input  tfo_flags_t            flags_in,
    output logic                  root_valid,
    input  logic                  root_ready,
    output logic [ROOT_W-1:0]     root,
    output logic [2:0][MN_W-1:0]  mn_out,
    output tfo_flags_t            flags_out
);

    localparam int NS = SQ_STAGES;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] adv;
    logic [NS-1:0] v_shift;

    // Pipeline control
    always_comb
    begin
        adv[NS-1] = !v_reg[NS-1] || root_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign v_shift    = {v_reg[NS-2:0], sum_valid};
    assign sum_ready  = adv[0];
    assign root_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_shift[k];
                end
            end
        end
    end

    tfo_sq_t              sq_reg  [NS];
    logic [SUM_W-1:0]     rad_reg [NS];
    logic [2:0][MN_W-1:0] mn_reg  [NS];
    tfo_flags_t           fl_reg  [NS];

    // Root stages: consume four radicand bits each
    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        tfo_sq_t              sq_prev;
        tfo_sq_t              sq_mid;
        tfo_sq_t              sq_next;
        logic [SUM_W-1:0]     rad_prev;
        logic [2:0][MN_W-1:0] mn_prev;
        tfo_flags_t           fl_prev;

        if (s == 0)
        begin : g_first
            assign sq_prev  = '0;
            assign rad_prev = lsum;
            assign mn_prev  = mn_in;
            assign fl_prev  = flags_in;
        end
        else
        begin : g_rest
            assign sq_prev  = sq_reg[s-1];
            assign rad_prev = rad_reg[s-1];
            assign mn_prev  = mn_reg[s-1];
            assign fl_prev  = fl_reg[s-1];
        end

        always_comb
        begin
            sq_mid  = sqrt_step(sq_prev, rad_prev[SUM_W-1 -: 2]);
            sq_next = sqrt_step(sq_mid, rad_prev[SUM_W-3 -: 2]);
        end

        always_ff @(posedge clk)
        begin
            if (adv[s])
            begin
                sq_reg[s]  <= sq_next;
                rad_reg[s] <= rad_prev << 4;
                mn_reg[s]  <= mn_prev;
                fl_reg[s]  <= fl_prev;
            end
        end
    end

    assign root      = sq_reg[NS-1].root;
    assign mn_out    = mn_reg[NS-1];
    assign flags_out = fl_reg[NS-1];

endmodule

### sv/tfo_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfo_div
// Three-lane pipelined restoring division m * 2^FRAC_BITS / R with rounding,
// two quotient bits per stage, then sign, zeroing and the result register.
// ----------------------------------------------------------------------------
module tfo_div
    import tfo_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  root_valid,
    output logic                  root_ready,
    input  logic [ROOT_W-1:0]     root,
    input  logic [2:0][MN_W-1:0]  mn,
    input  tfo_flags_t            flags_in,
    output logic                  frm_valid,
    input  logic                  frm_ready,
    output tfo_out_t              frm_data
);

    localparam int Q     = FRAC_BITS + 1;
    localparam int DS    = (Q + 1) / 2;
    localparam int NS    = DS + 2;
    localparam int NUM_W = MN_W + FRAC_BITS + 1;
    localparam int OQ_W  = (Q > VEC_W) ? Q : VEC_W;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] adv;
    logic [NS-1:0] v_shift;

    // Pipeline control
    always_comb
    begin
        adv[NS-1] = !v_reg[NS-1] || frm_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign v_shift    = {v_reg[NS-2:0], root_valid};
    assign root_ready = adv[0];
    assign frm_valid  = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_shift[k];
                end
            end
        end
    end

    logic [DREM_W-1:0] rem_reg  [DS+1][3];
    logic [Q-1:0]      nlow_reg [DS+1][3];
    logic [Q-1:0]      q_reg    [DS+1][3];
    logic [ROOT_W-1:0] r_reg    [DS+1];
    tfo_flags_t        fl_reg   [DS+1];

    // Prep stage: rounded numerator, split into initial remainder and low bits
    logic [NUM_W-1:0] num_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_next[i] = (NUM_W'(mn[i]) << FRAC_BITS) + NUM_W'(root >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i]  <= DREM_W'(num_next[i][NUM_W-1:Q]);
                nlow_reg[0][i] <= num_next[i][Q-1:0];
                q_reg[0][i]    <= '0;
            end
            r_reg[0]  <= root;
            fl_reg[0] <= flags_in;
        end
    end

    // Quotient stages
    for (genvar s = 1; s <= DS; s++)
    begin : g_stage
        logic [DREM_W-1:0] rem_next  [3];
        logic [Q-1:0]      nlow_next [3];
        logic [Q-1:0]      q_next    [3];
        tfo_div_t          st;

        always_comb
        begin
            st = '0;
            for (int i = 0; i < 3; i++)
            begin
                rem_next[i]  = rem_reg[s-1][i];
                nlow_next[i] = nlow_reg[s-1][i];
                q_next[i]    = q_reg[s-1][i];
                for (int k = 0; k < 2; k++)
                begin
                    if (2 * (s - 1) + k < Q)
                    begin
                        st           = div_step(rem_next[i], r_reg[s-1], nlow_next[i][Q-1]);
                        rem_next[i]  = st.rem;
                        q_next[i]    = {q_next[i][Q-2:0], st.qbit};
                        nlow_next[i] = nlow_next[i] << 1;
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[s])
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[s][i]  <= rem_next[i];
                    nlow_reg[s][i] <= nlow_next[i];
                    q_reg[s][i]    <= q_next[i];
                end
                r_reg[s]  <= r_reg[s-1];
                fl_reg[s] <= fl_reg[s-1];
            end
        end
    end

    // Output stage: apply sign, zero a degenerate frame
    logic [OQ_W-1:0] qe  [3];
    logic [OQ_W-1:0] qs  [3];
    tfo_out_t        out_next;
    tfo_out_t        out_reg;
    tfo_flags_t      fl_last;

    always_comb
    begin
        fl_last = fl_reg[DS];
        for (int i = 0; i < 3; i++)
        begin
            qe[i] = OQ_W'(q_reg[DS][i]);
            qs[i] = fl_last.neg[i] ? (~qe[i] + OQ_W'(1)) : qe[i];
            if (fl_last.degenerate)
            begin
                qs[i] = '0;
            end
        end
        out_next.out_x           = qs[0][VEC_W-1:0];
        out_next.out_y           = qs[1][VEC_W-1:0];
        out_next.out_z           = qs[2][VEC_W-1:0];
        out_next.handed_negative = fl_last.handed_negative;
        out_next.degenerate      = fl_last.degenerate;
        out_next.last_out        = fl_last.last;
    end

    always_ff @(posedge clk)
    begin
        if (adv[NS-1])
        begin
            out_reg <= out_next;
        end
    end

    assign frm_data = out_reg;

    // Normalized magnitudes give a root of at least 2^30
    assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] && !fl_reg[0].degenerate |-> r_reg[0][ROOT_W-1 -: 2] != 2'b00)
        else $error("root below normalized range");

    // Quotient must fit in FRAC_BITS+1 bits: initial remainder below divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] && !fl_reg[0].degenerate |->
            (rem_reg[0][0] < DREM_W'(r_reg[0])) && (rem_reg[0][1] < DREM_W'(r_reg[0]))
            && (rem_reg[0][2] < DREM_W'(r_reg[0])))
        else $error("quotient overflow");

    // A degenerate result carries a zero tangent
    assert property (@(posedge clk) disable iff (!rst_n)
        frm_valid && frm_data.degenerate |->
            (frm_data.out_x == '0) && (frm_data.out_y == '0) && (frm_data.out_z == '0))
        else $error("degenerate result with nonzero tangent");

endmodule

### sv/tangent_frame_orthonormalize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tangent_frame_orthonormalize
// Per-vertex Gram-Schmidt tangent orthonormalization with handedness bit.
// ----------------------------------------------------------------------------
// Usage:
//   The vtx channel takes one vertex per transaction (tangent, normal,
//   bitangent in signed fixed point, plus the last-vertex mark). The frm
//   channel returns one result per vertex, in order: the unit tangent, the
//   handedness bit, the degenerate flag and the copied last mark.
//   Both channels use valid/ready; a transaction completes when both are high.
//   Throughput is one vertex per cycle while frm is ready, vertices being independent.
//   From vtx to frm a vertex passes 5 front stages, 4 normalization
//   stages, 16 square-root stages at two root bits each, one division prep
//   stage, ceil((FRAC_BITS+1)/2) division stages at two quotient bits each
//   and the result register.
//   When frm stalls, results hold in place and vertices still enter while any
//   pipeline stage is empty; vtx_ready drops only when every stage is full.
//   Reset clears all valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
module tangent_frame_orthonormalize
    import tfo_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     vtx_valid,
    output logic     vtx_ready,
    input  tfo_in_t  vtx_data,
    output logic     frm_valid,
    input  logic     frm_ready,
    output tfo_out_t frm_data
);

    localparam int U_W = tfo_u_width(FRAC_BITS);

    logic                 mag_valid;
    logic                 mag_ready;
    logic [2:0][U_W-1:0]  mag;
    logic [U_W-1:0]       mag_max;
    tfo_flags_t           mag_flags;
    logic                 sum_valid;
    logic                 sum_ready;
    logic [SUM_W-1:0]     lsum;
    logic [2:0][MN_W-1:0] sum_mn;
    tfo_flags_t           sum_flags;
    logic                 root_valid;
    logic                 root_ready;
    logic [ROOT_W-1:0]    root;
    logic [2:0][MN_W-1:0] root_mn;
    tfo_flags_t           root_flags;

    // Dot, orthogonalization, determinant, magnitudes
    tfo_front #(
        .FRAC_BITS (FRAC_BITS),
        .U_W       (U_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .vtx_data  (vtx_data),
        .mag_valid (mag_valid),
        .mag_ready (mag_ready),
        .mag       (mag),
        .mag_max   (mag_max),
        .flags     (mag_flags)
    );

    // Scale and sum of squares
    tfo_norm #(
        .U_W (U_W)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .mag_valid (mag_valid),
        .mag_ready (mag_ready),
        .mag       (mag),
        .mag_max   (mag_max),
        .flags_in  (mag_flags),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .lsum      (lsum),
        .mn        (sum_mn),
        .flags_out (sum_flags)
    );

    // Length
    tfo_sqrt u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .sum_valid  (sum_valid),
        .sum_ready  (sum_ready),
        .lsum       (lsum),
        .mn_in      (sum_mn),
        .flags_in   (sum_flags),
        .root_valid (root_valid),
        .root_ready (root_ready),
        .root       (root),
        .mn_out     (root_mn),
        .flags_out  (root_flags)
    );

    // Divide by length, sign and result register
    tfo_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .root_valid (root_valid),
        .root_ready (root_ready),
        .root       (root),
        .mn         (root_mn),
        .flags_in   (root_flags),
        .frm_valid  (frm_valid),
        .frm_ready  (frm_ready),
        .frm_data   (frm_data)
    );

endmodule
